/* rtl/core/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// shared constants and request codes of the sorted stream merger
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int NUM_STREAMS  = 4;
    localparam int STREAM_DEPTH = 16;

    // fixed field widths
    localparam int REQ_W = 2;
    localparam int SID_W = 2;
    localparam int VAL_W = 32;

    // derived widths
    localparam int ADDR_W = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STREAM_DEPTH + 1);
    localparam int IDX_W  = $clog2(NUM_STREAMS);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

endpackage

/* rtl/core/sorted_stream_merger.sv */
// ----------------------------------------------------------------------------
// sorted_stream_merger
// k-way merge of ascending streams held in per-stream buffers
// ----------------------------------------------------------------------------
// latency: a result word is valid in the cycle after its request word is accepted
// throughput: one request word per cycle while the result side takes each word
// the head of every stream sits in a registered buffer read port, so a pop
// compares all heads in the accepting cycle
// reset clears write counts, read pointers and the result valid; buffer
// contents stay undefined until written
module sorted_stream_merger
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ssm_pkg::VAL_W-1:0]   s_axis_tdata,   // value
    input  logic [7:0]                  s_axis_tuser,   // req_type, stream_id, zero pad

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ssm_pkg::VAL_W-1:0]   m_axis_tdata,   // merged_value
    output logic [7:0]                  m_axis_tuser    // is_empty, overflow, zero pad
);

    localparam int NS = ssm_pkg::NUM_STREAMS;
    localparam int AW = ssm_pkg::ADDR_W;
    localparam int CW = ssm_pkg::CNT_W;
    localparam int IW = ssm_pkg::IDX_W;
    localparam int VW = ssm_pkg::VAL_W;

    logic                       accept;
    ssm_pkg::req_t              req;
    logic [ssm_pkg::SID_W-1:0]  sid;
    logic signed [VW-1:0]       in_val;

    logic [CW-1:0]              wr_cnt_reg  [NS];
    logic [CW-1:0]              wr_cnt_next [NS];
    logic [CW-1:0]              rd_ptr_reg  [NS];
    logic [CW-1:0]              rd_ptr_next [NS];
    logic signed [VW-1:0]       head        [NS];
    logic [NS-1:0]              nonempty;
    logic [NS-1:0]              wr_en;

    logic                       do_load;
    logic                       do_pop;
    logic                       do_clear;
    logic                       sid_ok;
    logic                       sid_full;
    logic                       found;
    logic [IW-1:0]              best_idx;
    logic signed [VW-1:0]       best_val;

    logic                       out_valid_reg;
    logic signed [VW-1:0]       out_value_reg;
    logic                       out_empty_reg;
    logic                       out_over_reg;
    logic signed [VW-1:0]       out_value_next;
    logic                       out_empty_next;
    logic                       out_over_next;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign req           = ssm_pkg::req_t'(s_axis_tuser[1:0]);
    assign sid           = s_axis_tuser[3:2];
    assign in_val        = s_axis_tdata;

    // request decode
    always_comb
    begin
        do_load  = 1'b0;
        do_pop   = 1'b0;
        do_clear = 1'b0;
        unique case (req)
            ssm_pkg::REQ_LOAD:  do_load  = accept;
            ssm_pkg::REQ_POP:   do_pop   = accept;
            ssm_pkg::REQ_CLEAR: do_clear = accept;
            default:
            begin
                do_load  = 1'b0;
                do_pop   = 1'b0;
                do_clear = 1'b0;
            end
        endcase
    end

    // target stream of a load and whether it has room
    always_comb
    begin
        sid_ok   = (int'(sid) < NS);
        sid_full = 1'b0;
        for (int s = 0; s < NS; s++)
        begin
            if (int'(sid) == s)
            begin
                sid_full = (wr_cnt_reg[s] == CW'(ssm_pkg::STREAM_DEPTH));
            end
        end
    end

    // streams that still hold unread words
    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            nonempty[s] = (rd_ptr_reg[s] < wr_cnt_reg[s]);
        end
    end

    // smallest head among streams with unread words, lowest index on a tie
    always_comb
    begin
        found    = 1'b0;
        best_idx = '0;
        best_val = '0;
        for (int s = 0; s < NS; s++)
        begin
            if (nonempty[s] && (!found || (head[s] < best_val)))
            begin
                found    = 1'b1;
                best_idx = IW'(s);
                best_val = head[s];
            end
        end
    end

    // pointer updates
    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            wr_en[s]       = do_load && sid_ok && !sid_full && (int'(sid) == s);
            wr_cnt_next[s] = wr_cnt_reg[s];
            rd_ptr_next[s] = rd_ptr_reg[s];
            if (do_clear)
            begin
                wr_cnt_next[s] = '0;
                rd_ptr_next[s] = '0;
            end
            else
            begin
                if (wr_en[s])
                begin
                    wr_cnt_next[s] = wr_cnt_reg[s] + CW'(1);
                end
                if (do_pop && found && (best_idx == IW'(s)))
                begin
                    rd_ptr_next[s] = rd_ptr_reg[s] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                wr_cnt_reg[s] <= '0;
                rd_ptr_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                wr_cnt_reg[s] <= wr_cnt_next[s];
                rd_ptr_reg[s] <= rd_ptr_next[s];
            end
        end
    end

    // one buffer per stream; the registered read port always holds the head
    for (genvar g = 0; g < NS; g++)
    begin : g_strm
        logic signed [VW-1:0] mem [ssm_pkg::STREAM_DEPTH];
        logic signed [VW-1:0] head_reg;
        logic [AW-1:0]        waddr;
        logic [AW-1:0]        raddr;

        assign waddr   = wr_cnt_reg[g][AW-1:0];
        assign raddr   = rd_ptr_next[g][AW-1:0];
        assign head[g] = head_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en[g])
            begin
                mem[waddr] <= in_val;
            end
        end

        // bypass covers a load into an empty stream
        always_ff @(posedge clk)
        begin
            if (wr_en[g] && (waddr == raddr))
            begin
                head_reg <= in_val;
            end
            else
            begin
                head_reg <= mem[raddr];
            end
        end
    end

    // result word
    always_comb
    begin
        out_value_next = '0;
        out_empty_next = 1'b0;
        out_over_next  = 1'b0;
        if (do_load && sid_ok && sid_full)
        begin
            out_over_next = 1'b1;
        end
        if (do_pop)
        begin
            if (found)
            begin
                out_value_next = best_val;
            end
            else
            begin
                out_empty_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg <= out_value_next;
            out_empty_reg <= out_empty_next;
            out_over_reg  <= out_over_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {6'b0, out_over_reg, out_empty_reg};

    // checks
    logic ptr_ok;
    logic cnt_ok;

    always_comb
    begin
        ptr_ok = 1'b1;
        cnt_ok = 1'b1;
        for (int s = 0; s < NS; s++)
        begin
            if (rd_ptr_reg[s] > wr_cnt_reg[s])
            begin
                ptr_ok = 1'b0;
            end
            if (wr_cnt_reg[s] > CW'(ssm_pkg::STREAM_DEPTH))
            begin
                cnt_ok = 1'b0;
            end
        end
    end

    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n) ptr_ok)
        else $error("read pointer passed write count");

    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n) cnt_ok)
        else $error("write count beyond stream depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("empty and overflow flagged together");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && (nonempty == '0)) |=> (m_axis_tvalid && m_axis_tuser[0]))
        else $error("pop of exhausted streams not flagged empty");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (nonempty == '0))
        else $error("stream still holds words after clear");

endmodule
